FILE: hw/rtl/byte_sbox_add_rotate_cipher_ops_macros.svh
// ----------------------------------------------------------------------------
// byte_sbox_add_rotate_cipher_ops_macros: assertion macros
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef BYTE_SBOX_ADD_ROTATE_CIPHER_OPS_MACROS_SVH
`define BYTE_SBOX_ADD_ROTATE_CIPHER_OPS_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bsarc_pkg.sv
// ----------------------------------------------------------------------------
// bsarc_pkg: operation codes, widths and substitution tables
// Shared constants for the byte cipher primitive.
// ----------------------------------------------------------------------------
`default_nettype none

package bsarc_pkg;

    localparam int unsigned NUM_BYTES = 8;
    localparam int unsigned WORD_W    = 8 * NUM_BYTES;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_SUB     = 2'd1,
        OP_ROT     = 2'd2,
        OP_INV_ROT = 2'd3
    } t_op;

    typedef logic [7:0] t_sbox [256];

    localparam t_sbox SBOX = '{
        8'd52, 8'd91, 8'd130, 8'd169, 8'd208, 8'd247, 8'd30, 8'd71,
        8'd112, 8'd153, 8'd194, 8'd235, 8'd20, 8'd63, 8'd106, 8'd149,
        8'd192, 8'd236, 8'd23, 8'd68, 8'd114, 8'd159, 8'd204, 8'd250,
        8'd39, 8'd86, 8'd134, 8'd181, 8'd228, 8'd19, 8'd70, 8'd120,
        8'd170, 8'd219, 8'd12, 8'd64, 8'd117, 8'd168, 8'd221, 8'd16,
        8'd73, 8'd126, 8'd180, 8'd234, 8'd34, 8'd90, 8'd146, 8'd203,
        8'd4, 8'd61, 8'd123, 8'd183, 8'd242, 8'd45, 8'd105, 8'd167,
        8'd230, 8'd37, 8'd100, 8'd164, 8'd229, 8'd40, 8'd104, 8'd174,
        8'd241, 8'd51, 8'd122, 8'd191, 8'd5, 8'd78, 8'd148, 8'd220,
        8'd38, 8'd113, 8'd189, 8'd8, 8'd85, 8'd162, 8'd244, 8'd65,
        8'd144, 8'd225, 8'd53, 8'd137, 8'd217, 8'd48, 8'd136, 8'd222,
        8'd55, 8'd143, 8'd237, 8'd72, 8'd161, 8'd0, 8'd95, 8'd193,
        8'd29, 8'd131, 8'd231, 8'd77, 8'd178, 8'd24, 8'd129, 8'd239,
        8'd88, 8'd198, 8'd49, 8'd163, 8'd18, 8'd138, 8'd254, 8'd111,
        8'd233, 8'd98, 8'd216, 8'd92, 8'd213, 8'd89, 8'd215, 8'd97,
        8'd232, 8'd110, 8'd253, 8'd135, 8'd21, 8'd166, 8'd56, 8'd202,
        8'd101, 8'd2, 8'd156, 8'd58, 8'd214, 8'd128, 8'd36, 8'd206,
        8'd125, 8'd43, 8'd223, 8'd151, 8'd76, 8'd10, 8'd197, 8'd141,
        8'd80, 8'd26, 8'd238, 8'd184, 8'd142, 8'd99, 8'd62, 8'd32,
        8'd9, 8'd248, 8'd218, 8'd205, 8'd196, 8'd190, 8'd195, 8'd201,
        8'd212, 8'd246, 8'd11, 8'd41, 8'd75, 8'd116, 8'd160, 8'd224,
        8'd31, 8'd102, 8'd175, 8'd14, 8'd107, 8'd200, 8'd66, 8'd177,
        8'd59, 8'd187, 8'd93, 8'd3, 8'd165, 8'd96, 8'd42, 8'd252,
        8'd207, 8'd176, 8'd171, 8'd173, 8'd199, 8'd251, 8'd44, 8'd109,
        8'd186, 8'd54, 8'd158, 8'd79, 8'd1, 8'd179, 8'd140, 8'd132,
        8'd147, 8'd209, 8'd25, 8'd119, 8'd17, 8'd182, 8'd133, 8'd127,
        8'd172, 8'd22, 8'd139, 8'd74, 8'd60, 8'd94, 8'd227, 8'd118,
        8'd108, 8'd188, 8'd81, 8'd67, 8'd154, 8'd84, 8'd152, 8'd69,
        8'd150, 8'd103, 8'd6, 8'd46, 8'd50, 8'd35, 8'd28, 8'd47,
        8'd145, 8'd57, 8'd157, 8'd226, 8'd7, 8'd240, 8'd87, 8'd83,
        8'd82, 8'd13, 8'd210, 8'd121, 8'd15, 8'd33, 8'd27, 8'd245,
        8'd211, 8'd124, 8'd115, 8'd155, 8'd185, 8'd243, 8'd249, 8'd255
    };

    // The forward table is a permutation, so the inverse is built by scattering.
    function automatic t_sbox build_inv_sbox();
        t_sbox inv;
        for (int k = 0; k < 256; k++) begin
            inv[k] = 8'd0;
        end
        for (int k = 0; k < 256; k++) begin
            inv[SBOX[k]] = 8'(k);
        end
        return inv;
    endfunction

    localparam t_sbox INV_SBOX = build_inv_sbox();

endpackage

`default_nettype wire

FILE: hw/rtl/byte_sbox_add_rotate_cipher_ops.sv
// ----------------------------------------------------------------------------
// byte_sbox_add_rotate_cipher_ops: byte-wise cipher primitive
// Add with S-box, inverse subtract, rotate-xnor and its inverse on 64 bits.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | direction
//  command  | i_start, o_busy, i_operation, i_operand_a/b  | in, o_busy out
//  result   | o_valid, o_result                            | out
//
// One transaction is taken per cycle; the result strobes in the cycle
// after the operands were registered. The add/subtract byte ripple chain
// with the table lookups sets the path. o_busy stays low: the receiver
// cannot stall. Reset clears the valid flags.
`default_nettype none

`include "byte_sbox_add_rotate_cipher_ops_macros.svh"

module byte_sbox_add_rotate_cipher_ops
    import bsarc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_operation,
    input  wire logic [WORD_W-1:0] i_operand_a,
    input  wire logic [WORD_W-1:0] i_operand_b,
    output logic                   o_valid,
    output logic [WORD_W-1:0]      o_result
);

    logic              r_in_vld;
    t_op               r_op;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_res;
    logic [WORD_W-1:0] n_res;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_start;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op <= t_op'(i_operation);
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        logic [8:0]        sum;
        logic [7:0]        x;
        logic [8:0]        y;
        logic              cy;
        logic [WORD_W-1:0] t;
        n_res = '0;
        sum   = '0;
        x     = '0;
        y     = '0;
        cy    = 1'b0;
        t     = ~(r_a ^ r_b);
        case (r_op)
            OP_ADD: begin
                // Byte 0 sits in the low bits, so the carry runs upward.
                for (int i = 0; i < NUM_BYTES; i++) begin
                    sum = {1'b0, r_a[8*i +: 8]} + {1'b0, r_b[8*i +: 8]} + {8'd0, cy};
                    cy  = sum[8];
                    n_res[8*i +: 8] = SBOX[sum[7:0]];
                end
            end
            OP_SUB: begin
                for (int i = 0; i < NUM_BYTES; i++) begin
                    x   = INV_SBOX[r_a[8*i +: 8]];
                    y   = {1'b0, r_b[8*i +: 8]} + {8'd0, cy};
                    sum = {1'b0, x} - y;
                    cy  = sum[8];
                    n_res[8*i +: 8] = sum[7:0];
                end
            end
            OP_ROT: begin
                n_res = ~({r_a[WORD_W-17:0], r_a[WORD_W-1:WORD_W-16]} ^ r_b);
            end
            default: begin
                n_res = {t[15:0], t[WORD_W-1:16]};
            end
        endcase
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_res;

    `BSC_ASSERT_NEXT(a_start_to_stage, i_clk, i_rst_n, i_start, r_in_vld,
        "accepted command did not reach the operand stage")
    `BSC_ASSERT_NEXT(a_stage_to_out, i_clk, i_rst_n, r_in_vld, o_valid,
        "operand stage did not produce a result strobe")
    `BSC_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy,
        "block reported busy")

endmodule

`default_nettype wire
